@@ sv/mrr_pkg.sv @@
// Shared types and constants for the response receiver.
`timescale 1ns / 1ps
package mrr_pkg;
  localparam logic [1:0] CMD_ARM  = 2'd0;
  localparam logic [1:0] CMD_BYTE = 2'd1;
  localparam logic [1:0] CMD_TICK = 2'd2;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_CRC      = 3'd1;
  localparam logic [2:0] ST_EXC      = 3'd2;
  localparam logic [2:0] ST_TIMEOUT  = 3'd3;
  localparam logic [2:0] ST_OVERFLOW = 3'd4;

  localparam logic [0:0] CFG_WORD_SWAP = 1'd0;
  localparam logic [0:0] CFG_TIMEOUT   = 1'd1;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] rx_byte;
    logic [7:0] expected_slave;
    logic [6:0] expected_func;
  } item_t;

  // One job from the front to the back: a single status, or a word list.
  typedef struct packed {
    logic       words;     // 1: emit nwords stored words
    logic [2:0] status;
    logic [7:0] exc;
    logic [6:0] nwords;
  } job_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction
endpackage

@@ sv/mrr_front.sv @@
// Frame parser: hunts the header, runs the CRC, stores words, raises jobs.
`timescale 1ns / 1ps
module mrr_front #(
  parameter int MAX_REGS = 32,
  parameter int AW = 5
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  mrr_pkg::item_t     item,
  input  logic               word_swap,
  input  logic [15:0]        timeout_ticks,
  input  logic               store_busy,
  output logic               job_valid,
  input  logic               job_ready,
  output mrr_pkg::job_t      job,
  output logic               wr_en,
  output logic [AW-1:0]      wr_addr,
  output logic [15:0]        wr_data
);
  localparam logic [2:0] PH_IDLE = 3'd0, PH_HUNT0 = 3'd1, PH_HUNT1 = 3'd2,
                         PH_COUNT = 3'd3, PH_BODY = 3'd4, PH_STALL = 3'd5;

  logic [2:0]  phase_r, phase_nxt;
  logic [7:0]  want_slave_r, want_slave_nxt;
  logic [6:0]  want_func_r, want_func_nxt;
  logic [7:0]  func_r, func_nxt;
  logic [8:0]  taken_r, taken_nxt;
  logic [8:0]  flen_r, flen_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  h0_r, h0_nxt, h1_r, h1_nxt;
  logic [7:0]  exc_r, exc_nxt;
  logic [15:0] ticks_r, ticks_nxt;
  logic        jv_r, jv_nxt;
  mrr_pkg::job_t job_r, job_nxt;
  logic [15:0] crc_in;
  logic [8:0]  d;
  logic [7:0]  b;
  logic [8:0]  flen_m5;
  logic [7:0]  words8;
  logic        acc;

  // Take an item only when no job is waiting and the back is not reading the store.
  assign in_ready  = !jv_r && !store_busy;
  assign acc       = in_valid && in_ready;
  assign job_valid = jv_r;
  assign job       = job_r;
  assign b         = item.rx_byte;
  assign crc_in    = mrr_pkg::crc_byte(crc_r, b);
  assign d         = taken_r - 9'd3;
  assign flen_m5   = flen_r - 9'd5;
  assign words8    = flen_m5[8:1];  // (flen-5)/2

  always_comb begin
    phase_nxt = phase_r; want_slave_nxt = want_slave_r; want_func_nxt = want_func_r;
    func_nxt = func_r; taken_nxt = taken_r; flen_nxt = flen_r; crc_nxt = crc_r;
    h0_nxt = h0_r; h1_nxt = h1_r; exc_nxt = exc_r; ticks_nxt = ticks_r;
    jv_nxt = jv_r && !job_ready; job_nxt = job_r;
    wr_en = 1'b0; wr_addr = d[AW:1]; wr_data = word_swap ? {b, h0_r} : {h0_r, b};
    if (acc) begin
      if (item.cmd == mrr_pkg::CMD_ARM) begin
        want_slave_nxt = item.expected_slave; want_func_nxt = item.expected_func;
        ticks_nxt = '0; phase_nxt = PH_HUNT0; taken_nxt = '0; flen_nxt = '0;
        func_nxt = '0; crc_nxt = mrr_pkg::CRC_INIT;
      end else if (phase_r != PH_IDLE && item.cmd == mrr_pkg::CMD_TICK) begin
        if (ticks_r != 16'hFFFF) ticks_nxt = ticks_r + 16'd1;
        if (ticks_nxt > timeout_ticks) begin
          phase_nxt = PH_IDLE; jv_nxt = 1'b1;
          job_nxt = '{words: 1'b0, status: mrr_pkg::ST_TIMEOUT, exc: 8'd0, nwords: 7'd0};
        end
      end else if (phase_r != PH_IDLE && item.cmd == mrr_pkg::CMD_BYTE) begin
        case (phase_r)
          PH_HUNT0: begin
            if (b == want_slave_r) begin
              phase_nxt = PH_HUNT1; crc_nxt = mrr_pkg::crc_byte(mrr_pkg::CRC_INIT, b);
              taken_nxt = 9'd1;
            end
          end
          PH_HUNT1: begin
            if (b[6:0] == want_func_r) begin
              func_nxt = b; crc_nxt = crc_in; taken_nxt = 9'd2;
              if (b == 8'd3) phase_nxt = PH_COUNT;
              else if (b == 8'd6) begin flen_nxt = 9'd8; phase_nxt = PH_BODY; end
              else if (b[7]) begin flen_nxt = 9'd5; phase_nxt = PH_BODY; end
              else phase_nxt = PH_STALL;
            end else if (b == want_slave_r) begin
              crc_nxt = mrr_pkg::crc_byte(mrr_pkg::CRC_INIT, b); taken_nxt = 9'd1;
            end else begin
              phase_nxt = PH_HUNT0; taken_nxt = '0;
            end
          end
          PH_COUNT: begin
            crc_nxt = crc_in; taken_nxt = 9'd3;
            if ({1'b0, b[7:1]} > 8'(MAX_REGS)) begin
              phase_nxt = PH_IDLE; jv_nxt = 1'b1;
              job_nxt = '{words: 1'b0, status: mrr_pkg::ST_OVERFLOW, exc: 8'd0, nwords: 7'd0};
            end else begin
              flen_nxt = 9'd5 + {1'b0, b}; phase_nxt = PH_BODY;
            end
          end
          PH_BODY: begin
            taken_nxt = taken_r + 9'd1;
            if (taken_r + 9'd2 < flen_r) begin
              crc_nxt = crc_in;
              if (func_r[7]) begin
                if (taken_r == 9'd2) exc_nxt = b;
              end else if (func_r == 8'd3 && taken_r >= 9'd3) begin
                if (!d[0]) h0_nxt = b;
                else if (d[8:1] < 8'(MAX_REGS)) wr_en = 1'b1;
              end
            end else if (taken_r + 9'd2 == flen_r) begin
              h1_nxt = b;
            end else begin
              phase_nxt = PH_IDLE; jv_nxt = 1'b1;
              if ({b, h1_r} != crc_r)
                job_nxt = '{words: 1'b0, status: mrr_pkg::ST_CRC, exc: 8'd0, nwords: 7'd0};
              else if (func_r[7])
                job_nxt = '{words: 1'b0, status: mrr_pkg::ST_EXC, exc: exc_r, nwords: 7'd0};
              else if (func_r == 8'd3 && words8 != 8'd0)
                job_nxt = '{words: 1'b1, status: mrr_pkg::ST_OK, exc: 8'd0,
                            nwords: words8[6:0]};
              else
                job_nxt = '{words: 1'b0, status: mrr_pkg::ST_OK, exc: 8'd0, nwords: 7'd0};
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE; jv_r <= 1'b0; ticks_r <= '0; taken_r <= '0; flen_r <= '0;
      want_slave_r <= '0; want_func_r <= '0; func_r <= '0; crc_r <= mrr_pkg::CRC_INIT;
      h0_r <= '0; h1_r <= '0; exc_r <= '0; job_r <= '0;
    end else begin
      phase_r <= phase_nxt; jv_r <= jv_nxt; ticks_r <= ticks_nxt; taken_r <= taken_nxt;
      flen_r <= flen_nxt; want_slave_r <= want_slave_nxt; want_func_r <= want_func_nxt;
      func_r <= func_nxt; crc_r <= crc_nxt; h0_r <= h0_nxt; h1_r <= h1_nxt;
      exc_r <= exc_nxt; job_r <= job_nxt;
    end
  end
endmodule

@@ sv/mrr_back.sv @@
// Result sequencer: owns the word store and streams each job's results.
`timescale 1ns / 1ps
module mrr_back #(
  parameter int MAX_REGS = 32,
  parameter int AW = 5
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          job_valid,
  output logic          job_ready,
  input  mrr_pkg::job_t job,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [15:0]   wr_data,
  output logic          store_busy,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [2:0]    out_status,
  output logic [7:0]    out_exception_code,
  output logic          out_has_data,
  output logic [4:0]    out_reg_index,
  output logic [15:0]   out_reg_value,
  output logic          out_last
);
  logic [15:0] mem [MAX_REGS];
  logic [15:0] rd_r;
  logic        busy_r;          // streaming words
  logic        rd_pend_r;       // read issued, data lands next cycle
  logic [6:0]  idx_r, cnt_r;
  logic        ov_r;
  logic [2:0]  st_r;
  logic [7:0]  ex_r;
  logic        hd_r, last_r;
  logic [6:0]  ridx_r;
  logic        out_free;
  logic        ov_set;
  logic [15:0] rd_hold, rd_hold_r;
  logic        cap_r;

  assign out_free   = !ov_r || out_ready;
  assign job_ready  = !busy_r && !rd_pend_r && out_free;
  assign store_busy = busy_r || rd_pend_r;
  assign ov_set     = (rd_pend_r && out_free) || (job_valid && job_ready && !job.words);

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_r <= mem[idx_r[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; rd_pend_r <= 1'b0; ov_r <= 1'b0; idx_r <= '0; cnt_r <= '0;
      st_r <= '0; ex_r <= '0; hd_r <= 1'b0; last_r <= 1'b0; ridx_r <= '0;
    end else begin
      ov_r <= ov_set || (ov_r && !out_ready);
      if (rd_pend_r && out_free) begin
        // read data is valid now; present it
        st_r <= mrr_pkg::ST_OK; ex_r <= '0; hd_r <= 1'b1;
        ridx_r <= idx_r; last_r <= (idx_r + 7'd1 == cnt_r);
        rd_pend_r <= 1'b0;
        if (idx_r + 7'd1 == cnt_r) busy_r <= 1'b0;
        else idx_r <= idx_r + 7'd1;
      end else if (busy_r && !rd_pend_r && out_free) begin
        rd_pend_r <= 1'b1;
      end else if (job_valid && job_ready) begin
        if (job.words) begin
          busy_r <= 1'b1; idx_r <= '0; cnt_r <= job.nwords;
        end else begin
          st_r <= job.status; ex_r <= job.exc; hd_r <= 1'b0;
          ridx_r <= '0; last_r <= 1'b1;
        end
      end
    end
  end

  assign out_valid          = ov_r;
  assign out_status         = st_r;
  assign out_exception_code = ex_r;
  assign out_has_data       = hd_r;
  assign out_reg_index      = ridx_r[4:0];
  assign out_reg_value      = hd_r ? rd_hold : 16'd0;

  // hold read data while the word waits on the output
  always_ff @(posedge clk) begin
    if (!rst_n) cap_r <= 1'b0;
    else cap_r <= rd_pend_r && out_free;
    if (cap_r) rd_hold_r <= rd_r;
  end
  assign rd_hold  = cap_r ? rd_r : rd_hold_r;
  assign out_last = last_r;
endmodule

@@ sv/modbus_response_receiver_unit.sv @@
// Top level: configuration registers, parser front, job queue, result back.
// Path: a status result goes from the job register to the output register; a
// register word goes from the job register through a store read, one word at a time.
// Throughput: one input item per cycle while no job waits and the back is not
// streaming register words; set by the one slot job register and the store.
// Reset: synchronous active low; idle, word_swap 0, timeout_ticks 1000.
`timescale 1ns / 1ps
module modbus_response_receiver_unit #(
  parameter int MAX_REGS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_cmd,
  input  logic [7:0]  in_rx_byte,
  input  logic [7:0]  in_expected_slave,
  input  logic [6:0]  in_expected_func,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [7:0]  out_exception_code,
  output logic        out_has_data,
  output logic [4:0]  out_reg_index,
  output logic [15:0] out_reg_value,
  output logic        out_last
);
  localparam int AW = (MAX_REGS > 1) ? $clog2(MAX_REGS) : 1;

  logic          swap_r;
  logic [15:0]   tmo_r;
  mrr_pkg::item_t item;
  mrr_pkg::job_t  job;
  logic          job_valid, job_ready, wr_en, store_busy;
  logic [AW-1:0] wr_addr;
  logic [15:0]   wr_data;

  assign cfg_ready = 1'b1;
  assign item = '{cmd: in_cmd, rx_byte: in_rx_byte, expected_slave: in_expected_slave,
                  expected_func: in_expected_func};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      swap_r <= 1'b0; tmo_r <= 16'd1000;
    end else if (cfg_valid) begin
      if (cfg_index == mrr_pkg::CFG_WORD_SWAP) swap_r <= cfg_data[0];
      else tmo_r <= cfg_data;
    end
  end

  mrr_front #(.MAX_REGS(MAX_REGS), .AW(AW)) u_front (
    .clk, .rst_n, .in_valid, .in_ready, .item, .word_swap(swap_r),
    .timeout_ticks(tmo_r), .store_busy, .job_valid, .job_ready, .job, .wr_en, .wr_addr,
    .wr_data
  );

  mrr_back #(.MAX_REGS(MAX_REGS), .AW(AW)) u_back (
    .clk, .rst_n, .job_valid, .job_ready, .job, .wr_en, .wr_addr, .wr_data, .store_busy,
    .out_valid, .out_ready, .out_status, .out_exception_code, .out_has_data,
    .out_reg_index, .out_reg_value, .out_last
  );

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= mrr_pkg::ST_OVERFLOW) else $error("bad status");
  a_data_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_has_data |-> out_status == mrr_pkg::ST_OK) else $error("data status");
  a_exc_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != mrr_pkg::ST_EXC |-> out_exception_code == 8'd0)
    else $error("stray exception code");
endmodule

@@ tb/sv/modbus_response_receiver_unit_test.sv @@
// Self-checking testbench for the response receiver: framed traffic, noise, stalls.
`timescale 1ns / 1ps
module modbus_response_receiver_unit_test;
  localparam logic [1:0] CMD_NONE = 2'd3;
  localparam int LIMIT = 400000;
  localparam int WORDS_MAX = 32;
  localparam int DRAIN_CYCLES = 12;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  exc;
    logic        has_data;
    logic [4:0]  idx;
    logic [15:0] val;
    logic        last;
  } rsp_t;

  typedef enum logic [2:0] {P_IDLE, P_HUNT0, P_HUNT1, P_COUNT, P_BODY, P_STALL} phase_e;

  typedef struct {
    mrr_pkg::item_t it;
    bit    typed;
    rsp_t  r;
  } row_t;

  typedef enum int {
    FR_READ, FR_WRITE, FR_EXC, FR_BADCRC, FR_OVER, FR_ODDFUNC, FR_CUT
  } frame_e;

  logic        clk, rst_n;
  logic        in_valid, in_ready;
  logic [1:0]  in_cmd;
  logic [7:0]  in_rx_byte, in_expected_slave;
  logic [6:0]  in_expected_func;
  logic        cfg_valid, cfg_ready, cfg_index;
  logic [15:0] cfg_data;
  logic        out_valid, out_ready;
  logic [2:0]  out_status;
  logic [7:0]  out_exception_code;
  logic        out_has_data;
  logic [4:0]  out_reg_index;
  logic [15:0] out_reg_value;
  logic        out_last;

  modbus_response_receiver_unit dut (.*);

  // receiver model state
  bit          m_swap;
  logic [15:0] m_limit;
  phase_e      m_phase;
  logic [7:0]  m_slave;
  logic [6:0]  m_func;
  logic [7:0]  m_seen;
  int          m_taken, m_flen;
  logic [15:0] m_crc;
  logic [7:0]  m_hold [0:2];
  logic [7:0]  m_exc;
  logic [15:0] m_store [0:WORDS_MAX-1];
  logic [15:0] m_ticks;

  rsp_t fresh[$];
  rsp_t pending_rsp[$];
  row_t rows[$];
  int   errors = 0;
  int   cycles = 0;
  int   items_sent = 0;
  bit   calm = 0;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic flag(input string msg);
    errors++;
    if (errors <= 40) $display("mismatch @%0t: %s", $realtime, msg);
  endtask

  function automatic logic [15:0] crc_step(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] x;
    x = c ^ {8'h00, b};
    for (int i = 0; i < 8; i++) x = x[0] ? ((x >> 1) ^ 16'hA001) : (x >> 1);
    return x;
  endfunction

  function automatic void emit(input logic [2:0] st, input logic [7:0] exc, input logic hd,
                               input int idx, input logic [15:0] val, input logic lst);
    rsp_t r;
    r.status = st; r.exc = exc; r.has_data = hd;
    r.idx = idx[4:0]; r.val = val; r.last = lst;
    fresh.push_back(r);
  endfunction

  function automatic void close_frame();
    int words;
    m_phase = P_IDLE;
    if ({m_hold[2], m_hold[1]} != m_crc) emit(mrr_pkg::ST_CRC, 0, 0, 0, 0, 1);
    else if (m_seen >= 8'h80) emit(mrr_pkg::ST_EXC, m_exc, 0, 0, 0, 1);
    else if (m_seen == 8'd3) begin
      words = (m_flen - 5) / 2;
      if (words > WORDS_MAX) words = WORDS_MAX;
      if (words == 0) emit(mrr_pkg::ST_OK, 0, 0, 0, 0, 1);
      for (int i = 0; i < words; i++)
        emit(mrr_pkg::ST_OK, 0, 1, i, m_store[i], i + 1 == words);
    end else emit(mrr_pkg::ST_OK, 0, 0, 0, 0, 1);
  endfunction

  function automatic void lock_slave(input logic [7:0] b);
    m_phase = P_HUNT1;
    m_crc = crc_step(16'hFFFF, b);
    m_taken = 1;
  endfunction

  function automatic void take_rx(input logic [7:0] b);
    int p, d;
    logic [15:0] w;
    case (m_phase)
      P_HUNT0: if (b == m_slave) lock_slave(b);
      P_HUNT1: begin
        if (b[6:0] == m_func) begin
          m_seen = b;
          m_crc = crc_step(m_crc, b);
          m_taken = 2;
          if (b == 8'd3) m_phase = P_COUNT;
          else if (b == 8'd6) begin
            m_flen = 8; m_phase = P_BODY;
          end else if (b >= 8'h80) begin
            m_flen = 5; m_phase = P_BODY;
          end else m_phase = P_STALL;
        end else if (b == m_slave) lock_slave(b);
        else begin
          m_phase = P_HUNT0; m_taken = 0;
        end
      end
      P_COUNT: begin
        m_crc = crc_step(m_crc, b);
        m_taken = 3;
        if (b / 2 > WORDS_MAX) begin
          m_phase = P_IDLE;
          emit(mrr_pkg::ST_OVERFLOW, 0, 0, 0, 0, 1);
        end else begin
          m_flen = 5 + b; m_phase = P_BODY;
        end
      end
      P_BODY: begin
        p = m_taken;
        m_taken = (m_taken + 1) & 9'h1FF;
        if (p + 2 < m_flen) begin
          m_crc = crc_step(m_crc, b);
          if (m_seen >= 8'h80) begin
            if (p == 2) m_exc = b;
          end else if (m_seen == 8'd3 && p >= 3) begin
            d = p - 3;
            if (d % 2 == 0) m_hold[0] = b;
            else begin
              w = m_swap ? {b, m_hold[0]} : {m_hold[0], b};
              if (d / 2 < WORDS_MAX) m_store[d / 2] = w;
            end
          end
        end else if (p + 2 == m_flen) m_hold[1] = b;
        else begin
          m_hold[2] = b;
          close_frame();
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void rx_model_step(input mrr_pkg::item_t it);
    fresh.delete();
    if (it.cmd == mrr_pkg::CMD_ARM) begin
      m_slave = it.expected_slave; m_func = it.expected_func;
      m_ticks = 0; m_phase = P_HUNT0; m_taken = 0; m_flen = 0;
      m_seen = 0; m_crc = 16'hFFFF;
    end else if (m_phase != P_IDLE) begin
      if (it.cmd == mrr_pkg::CMD_BYTE) take_rx(it.rx_byte);
      else if (it.cmd == mrr_pkg::CMD_TICK) begin
        if (m_ticks != 16'hFFFF) m_ticks++;
        if (m_ticks > m_limit) begin
          m_phase = P_IDLE;
          emit(mrr_pkg::ST_TIMEOUT, 0, 0, 0, 0, 1);
        end
      end
    end
  endfunction

  always @(posedge clk) begin
    rsp_t e;
    if (rst_n && out_valid && out_ready) begin
      if (pending_rsp.size() == 0) flag($sformatf("unexpected word status %0d", out_status));
      else begin
        e = pending_rsp.pop_front();
        if (out_status !== e.status) flag($sformatf("status %0d want %0d", out_status, e.status));
        if (out_exception_code !== e.exc)
          flag($sformatf("exception_code %0h want %0h", out_exception_code, e.exc));
        if (out_has_data !== e.has_data)
          flag($sformatf("has_data %0b want %0b", out_has_data, e.has_data));
        if (out_reg_index !== e.idx) flag($sformatf("reg_index %0d want %0d", out_reg_index, e.idx));
        if (out_reg_value !== e.val) flag($sformatf("reg_value %0h want %0h", out_reg_value, e.val));
        if (out_last !== e.last) flag($sformatf("last %0b want %0b", out_last, e.last));
      end
    end
  end

  // random backpressure on the result side
  initial begin
    out_ready = 1;
    forever begin
      @(negedge clk);
      if (!calm && rst_n && $urandom_range(0, 9) == 0) begin
        out_ready <= 0;
        repeat ($urandom_range(1, 18)) @(negedge clk);
        out_ready <= 1;
      end
    end
  end

  // call at a falling edge; returns at a falling edge with valid still high
  task automatic put_item(input mrr_pkg::item_t it, input bit typed = 0,
                          input rsp_t tr = '0);
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    in_cmd <= it.cmd;
    in_rx_byte <= it.rx_byte;
    in_expected_slave <= it.expected_slave;
    in_expected_func <= it.expected_func;
    in_valid <= 1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    rx_model_step(it);
    if (typed) pending_rsp.push_back(tr);
    else foreach (fresh[i]) pending_rsp.push_back(fresh[i]);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic put_cmd(input logic [1:0] c, input logic [7:0] b = 0,
                         input logic [7:0] s = 0, input logic [6:0] f = 0);
    mrr_pkg::item_t it;
    it.cmd = c; it.rx_byte = b; it.expected_slave = s; it.expected_func = f;
    put_item(it);
  endtask

  // hold input until every expected word is out and the block has gone quiet
  task automatic settle();
    in_valid <= 0;
    while (pending_rsp.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_reg(input logic [0:0] idx, input logic [15:0] data);
    settle();
    cfg_index <= idx;
    cfg_data <= data;
    cfg_valid <= 1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == mrr_pkg::CFG_WORD_SWAP) m_swap = data[0];
    else m_limit = data;
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  function automatic void add_row(input logic [1:0] c, input logic [7:0] b,
                                  input logic [7:0] s, input logic [6:0] f,
                                  input bit typed = 0,
                                  input logic [2:0] st = mrr_pkg::ST_OK);
    row_t r;
    r.it.cmd = c; r.it.rx_byte = b; r.it.expected_slave = s; r.it.expected_func = f;
    r.typed = typed;
    r.r = '0;
    r.r.status = st;
    r.r.last = 1;
    rows.push_back(r);
  endfunction

  task automatic send_frame(input frame_e kind);
    logic [7:0] slave, fb, cnt;
    logic [6:0] want;
    logic [7:0] body[$];
    logic [15:0] c;
    int n, pos;
    slave = $urandom_range(0, 255);
    case (kind)
      FR_READ, FR_BADCRC, FR_OVER, FR_CUT: want = 7'd3;
      FR_WRITE: want = 7'd6;
      FR_EXC: want = $urandom_range(0, 1) ? 7'd3 : 7'd6;
      default: begin
        want = $urandom_range(0, 127);
        if (want == 7'd3 || want == 7'd6) want = 7'd0;
      end
    endcase
    put_cmd(mrr_pkg::CMD_ARM, $urandom_range(0, 255), slave, want);
    repeat ($urandom_range(0, 2)) begin
      fb = $urandom_range(0, 255);
      if (fb != slave) put_cmd(mrr_pkg::CMD_BYTE, fb);
    end
    fb = (kind == FR_EXC) ? {1'b1, want} : {1'b0, want};
    body.push_back(slave);
    body.push_back(fb);
    case (kind)
      FR_WRITE: repeat (4) body.push_back($urandom_range(0, 255));
      FR_EXC: body.push_back($urandom_range(0, 255));
      FR_OVER: body.push_back($urandom_range(66, 255));
      FR_ODDFUNC: repeat (3) body.push_back($urandom_range(0, 255));
      default: begin
        cnt = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 65) : $urandom_range(0, 9);
        body.push_back(cnt);
        repeat (cnt) body.push_back($urandom_range(0, 255));
      end
    endcase
    c = 16'hFFFF;
    foreach (body[i]) c = crc_step(c, body[i]);
    body.push_back(c[7:0]);
    body.push_back(c[15:8]);
    if (kind == FR_BADCRC) begin
      pos = $urandom_range(2, body.size() - 1);
      body[pos] = body[pos] ^ (8'h01 << $urandom_range(0, 7));
    end
    n = (kind == FR_CUT) ? $urandom_range(1, body.size() - 1) : body.size();
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 15) == 0) put_cmd(mrr_pkg::CMD_TICK, $urandom_range(0, 255));
      put_cmd(mrr_pkg::CMD_BYTE, body[i]);
    end
    if (kind == FR_CUT || kind == FR_ODDFUNC || $urandom_range(0, 5) == 0)
      repeat ($urandom_range(1, 8)) put_cmd(mrr_pkg::CMD_TICK);
  endtask

  task automatic send_noise();
    repeat ($urandom_range(1, 6))
      put_cmd($urandom_range(0, 3), $urandom_range(0, 255), $urandom_range(0, 255),
              $urandom_range(0, 127));
  endtask

  initial begin
    logic [15:0] limits[6];
    bit swaps[6];
    int mark;
    limits = '{16'd1000, 16'd65535, 16'd0, 16'd4, 16'd65535, 16'd7};
    swaps = '{0, 1, 1, 0, 1, 0};
    rst_n = 0;
    in_valid = 0; in_cmd = mrr_pkg::CMD_ARM; in_rx_byte = 0;
    in_expected_slave = 0; in_expected_func = 0;
    cfg_valid = 0; cfg_index = mrr_pkg::CFG_WORD_SWAP; cfg_data = 0;
    m_swap = 0; m_limit = 16'd1000; m_phase = P_IDLE;
    m_slave = 0; m_func = 0; m_seen = 0; m_taken = 0; m_flen = 0;
    m_crc = 16'hFFFF; m_exc = 0; m_ticks = 0;
    foreach (m_hold[i]) m_hold[i] = 0;
    foreach (m_store[i]) m_store[i] = 0;

    // not armed, then overflow, header hunt, bad crc on exception, odd function, re-arm
    add_row(mrr_pkg::CMD_BYTE, 8'hFF, 8'hFF, 7'h7F);
    add_row(mrr_pkg::CMD_TICK, 8'h00, 8'h00, 7'h00);
    add_row(CMD_NONE, 8'hA5, 8'h5A, 7'h2A);
    add_row(mrr_pkg::CMD_ARM, 8'h00, 8'h11, 7'd3);
    add_row(mrr_pkg::CMD_BYTE, 8'h00, 8'h00, 7'h00);
    add_row(mrr_pkg::CMD_BYTE, 8'h11, 8'h00, 7'h00);
    add_row(mrr_pkg::CMD_BYTE, 8'h11, 8'h00, 7'h00);
    add_row(mrr_pkg::CMD_BYTE, 8'h03, 8'h00, 7'h00);
    add_row(mrr_pkg::CMD_BYTE, 8'hFF, 8'h00, 7'h00, 1, mrr_pkg::ST_OVERFLOW);
    add_row(mrr_pkg::CMD_BYTE, 8'h11, 8'h00, 7'h00);
    add_row(mrr_pkg::CMD_ARM, 8'hFF, 8'hFF, 7'h7F);
    add_row(mrr_pkg::CMD_BYTE, 8'hFF, 8'h00, 7'h00);
    add_row(mrr_pkg::CMD_BYTE, 8'hFF, 8'h00, 7'h00);
    add_row(mrr_pkg::CMD_BYTE, 8'h01, 8'h00, 7'h00);
    add_row(mrr_pkg::CMD_BYTE, 8'h00, 8'h00, 7'h00);
    add_row(mrr_pkg::CMD_BYTE, 8'h00, 8'h00, 7'h00);
    add_row(mrr_pkg::CMD_ARM, 8'h00, 8'h00, 7'd5);
    add_row(mrr_pkg::CMD_BYTE, 8'h00, 8'h00, 7'h00);
    add_row(mrr_pkg::CMD_BYTE, 8'h05, 8'h00, 7'h00);
    add_row(mrr_pkg::CMD_BYTE, 8'hAA, 8'h00, 7'h00);
    add_row(mrr_pkg::CMD_ARM, 8'h00, 8'h22, 7'd6);
    add_row(mrr_pkg::CMD_BYTE, 8'h22, 8'h00, 7'h00);
    add_row(mrr_pkg::CMD_TICK, 8'h00, 8'h00, 7'h00);
    add_row(mrr_pkg::CMD_ARM, 8'h00, 8'h01, 7'd3);

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;
    @(negedge clk);
    foreach (rows[i]) put_item(rows[i].it, rows[i].typed, rows[i].r);

    for (int ph = 0; ph < 6; ph++) begin
      set_reg(mrr_pkg::CFG_WORD_SWAP, {15'd0, swaps[ph]});
      set_reg(mrr_pkg::CFG_TIMEOUT, limits[ph]);
      if (ph == 5) calm = 1;
      mark = items_sent;
      while (items_sent - mark < 50) begin
        if ($urandom_range(0, 9) == 0) send_noise();
        else if ($urandom_range(0, 2) == 0) send_frame(FR_READ);
        else send_frame(frame_e'($urandom_range(0, 6)));
      end
    end

    in_valid <= 0;
    while (pending_rsp.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule
